// File: hw/rtl/bpc_pkg.sv
// shared types and constants for the button press classifier
`default_nettype none

package bpc_pkg;

  // default counter width and register widths
  localparam int COUNT_WIDTH_DEFAULT = 16;
  localparam int CFG_W               = 16;
  localparam int PRESS_COUNT_W       = 16;

  // register reset values
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET   = 16'd1000;
  localparam logic [CFG_W-1:0] COUNT_WINDOW_RESET = 16'd500;

  // register indexes
  typedef enum logic [0:0] {
    REG_LONG_PRESS   = 1'b0,
    REG_COUNT_WINDOW = 1'b1
  } reg_index_t;

  // press phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_EDGE = 2'd1,
    PH_HELD = 2'd2
  } phase_t;

  // result kind
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_LONG  = 2'd2
  } kind_t;

endpackage

`default_nettype wire

// File: hw/rtl/button_press_classifier_unit.sv
// button press classifier top level: phase machine, hold and window counters
//
// Takes one sampled key level per word and returns one result word for each:
// the press kind (none, short on release, long once the hold reaches
// long_press_ticks) and, on the tick the counting window closes, the number of
// presses seen in it. A new word is accepted every cycle while in_stall is low;
// its result enters the output register in the next cycle, at a rate set
// by the phase, hold and window update loop; in_stall rises only while a result
// waits in the output register under out_stall. The user writes configuration
// via cfg_we/cfg_index/cfg_data only while idle; the unit does not enforce it.
`default_nettype none

module button_press_classifier_unit
  import bpc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration
  input  wire logic                     cfg_we,
  input  wire logic [0:0]               cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_data,
  // input channel
  input  wire logic                     in_valid,
  output      logic                     in_stall,
  input  wire logic                     key_level,
  // output channel
  output      logic                     out_valid,
  input  wire logic                     out_stall,
  output      logic [1:0]               press_kind,
  output      logic [PRESS_COUNT_W-1:0] press_count
);

  localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  localparam logic [CMP_W-1:0] COUNT_OUT_MAX = CMP_W'({PRESS_COUNT_W{1'b1}});

  // configuration registers
  logic [CFG_W-1:0] long_press_ticks;
  logic [CFG_W-1:0] count_window_ticks;

  // classifier state
  phase_t                 press_phase;
  logic                   previous_level;
  logic [COUNT_WIDTH-1:0] hold_ticks;
  logic                   window_open;
  logic [COUNT_WIDTH-1:0] window_ticks;
  logic [COUNT_WIDTH-1:0] window_presses;

  phase_t                     press_phase_next;
  logic [COUNT_WIDTH-1:0]     hold_ticks_next;
  logic                       window_open_next;
  logic [COUNT_WIDTH-1:0]     window_ticks_next;
  logic [COUNT_WIDTH-1:0]     window_presses_next;
  kind_t                      kind_next;
  logic [PRESS_COUNT_W-1:0]   count_next;

  phase_t                 phase_seen;
  phase_t                 phase_step;
  logic                   release_seen;
  logic                   long_seen;
  logic [COUNT_WIDTH-1:0] hold_inc;
  logic [COUNT_WIDTH-1:0] window_inc;
  logic [CMP_W-1:0]       presses_ext;
  logic                   accept;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
  endfunction

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks   <= LONG_PRESS_RESET;
      count_window_ticks <= COUNT_WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG_PRESS:   long_press_ticks   <= cfg_data;
        REG_COUNT_WINDOW: count_window_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // phase next state, edge and release detection
  always_comb begin
    phase_seen   = (!key_level && !previous_level) ? PH_IDLE : press_phase;
    phase_step   = phase_seen;
    release_seen = 1'b0;
    case (phase_seen)
      PH_IDLE: if (key_level && !previous_level) phase_step = PH_EDGE;
      PH_EDGE: if (key_level && previous_level) phase_step = PH_HELD;
      PH_HELD: release_seen = !key_level && previous_level;
      default: phase_step = PH_IDLE;
    endcase
  end

  // hold counter and press kind
  always_comb begin
    hold_inc        = sat_inc(hold_ticks);
    hold_ticks_next = hold_ticks;
    long_seen       = 1'b0;
    if (long_press_ticks != '0) begin
      if (phase_step == PH_HELD && !release_seen) hold_ticks_next = hold_inc;
      if (CMP_W'(hold_ticks_next) >= CMP_W'(long_press_ticks)) begin
        long_seen       = 1'b1;
        hold_ticks_next = '0;
      end
    end
    press_phase_next = phase_step;
    kind_next        = KIND_NONE;
    if (long_seen) begin
      press_phase_next = PH_IDLE;
      kind_next        = KIND_LONG;
    end else if (release_seen) begin
      press_phase_next = PH_IDLE;
      kind_next        = KIND_SHORT;
      hold_ticks_next  = '0;
    end
  end

  // counting window
  always_comb begin
    window_inc          = sat_inc(window_ticks);
    presses_ext         = CMP_W'(window_presses);
    window_open_next    = window_open || (kind_next == KIND_SHORT);
    window_ticks_next   = window_ticks;
    window_presses_next = window_presses;
    count_next          = '0;
    if (window_open_next) begin
      window_ticks_next = window_inc;
      if (CMP_W'(window_inc) >= CMP_W'(count_window_ticks)) begin
        window_open_next    = 1'b0;
        window_ticks_next   = '0;
        count_next          = PRESS_COUNT_W'((presses_ext > COUNT_OUT_MAX) ?
                                             COUNT_OUT_MAX : presses_ext);
        window_presses_next = '0;
      end else if (kind_next != KIND_NONE) begin
        window_presses_next = sat_inc(window_presses);
      end
    end
  end

  // state update on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      press_phase    <= PH_IDLE;
      previous_level <= 1'b0;
      hold_ticks     <= '0;
      window_open    <= 1'b0;
      window_ticks   <= '0;
      window_presses <= '0;
    end else if (accept) begin
      press_phase    <= press_phase_next;
      previous_level <= key_level;
      hold_ticks     <= hold_ticks_next;
      window_open    <= window_open_next;
      window_ticks   <= window_ticks_next;
      window_presses <= window_presses_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      press_kind  <= kind_next;
      press_count <= count_next;
    end
  end

  // a nonzero count only leaves on a window close
  assert property (@(posedge clk) disable iff (rst)
    out_valid && press_count != '0 |-> !window_open)
    else $error("press count shown while window still open");

  // long press disabled gives no long result
  assert property (@(posedge clk) disable iff (rst)
    accept && long_press_ticks == '0 |=> press_kind != KIND_LONG)
    else $error("long press reported while disabled");

  // a result taken with no new word accepted leaves the output register
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !accept |=> !out_valid)
    else $error("result not released after being taken");

  // short and long never come with the phase left busy
  assert property (@(posedge clk) disable iff (rst)
    accept && kind_next != KIND_NONE |=> press_phase == PH_IDLE)
    else $error("phase not idle after a press");

endmodule

`default_nettype wire
